// ===== hdl/rbd_pkg.sv =====
// shared types and constants for the ring buffer deque
`default_nettype none

package rbd_pkg;

    localparam int DEPTH = 1024;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_POP_FRONT  = 2'd1,
        FN_PUSH_BACK  = 2'd2,
        FN_POP_BACK   = 2'd3
    } func_e;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_POPPED = 2'd2,
        ST_EMPTY  = 2'd3
    } status_e;

    // operation broadcast to every cell of the chain
    typedef enum logic [3:0] {
        OP_HOLD,
        OP_PUSH_F,
        OP_POP_F,
        OP_PUSH_B,
        OP_POP_B,
        OP_SHIFT_L,
        OP_SHIFT_R,
        OP_CONV_L,
        OP_CONV_R
    } chain_op_e;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MIGRATE,
        FSM_EXEC
    } fsm_e;

    typedef struct packed {
        func_e                     func;
        logic signed [WORD_W-1:0]  value;
    } in_beat_t;

    typedef struct packed {
        status_e                   status;
        logic signed [WORD_W-1:0]  popped_word;
        logic                      matches_res;
    } out_beat_t;

    // contents of one cell: a word and its segment membership
    typedef struct packed {
        logic signed [WORD_W-1:0]  word;
        logic                      in_left;
        logic                      in_right;
    } cell_t;

    typedef struct packed {
        chain_op_e                 op;
        logic signed [WORD_W-1:0]  word;
    } chain_ctl_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  front_word;
        logic signed [WORD_W-1:0]  back_word;
        logic                      front_in_left;
        logic                      front_in_right;
        logic                      back_in_left;
        logic                      back_in_right;
    } chain_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rbd_cell.sv =====
// one storage cell of the deque chain
`default_nettype none

module rbd_cell
    import rbd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire chain_op_e op,
    input  wire cell_t     left_i,
    input  wire cell_t     right_i,
    output cell_t          state_o
);

    logic signed [WORD_W-1:0] word_reg, word_next;
    logic                     in_left_reg, in_left_next;
    logic                     in_right_reg, in_right_next;

    always_comb begin
        word_next     = word_reg;
        in_left_next  = in_left_reg;
        in_right_next = in_right_reg;
        unique case (op)
            OP_PUSH_F: begin
                if (in_left_reg || left_i.in_left) begin
                    word_next    = left_i.word;
                    in_left_next = left_i.in_left;
                end
            end
            OP_POP_F: begin
                if (in_left_reg) begin
                    word_next    = right_i.word;
                    in_left_next = right_i.in_left;
                end
            end
            OP_PUSH_B: begin
                if (in_right_reg || right_i.in_right) begin
                    word_next     = right_i.word;
                    in_right_next = right_i.in_right;
                end
            end
            OP_POP_B: begin
                if (in_right_reg) begin
                    word_next     = left_i.word;
                    in_right_next = left_i.in_right;
                end
            end
            OP_SHIFT_L: begin
                word_next     = right_i.word;
                in_right_next = right_i.in_right;
            end
            OP_SHIFT_R: begin
                word_next    = left_i.word;
                in_left_next = left_i.in_left;
            end
            OP_CONV_L: begin
                in_left_next  = in_left_reg | in_right_reg;
                in_right_next = 1'b0;
            end
            OP_CONV_R: begin
                in_right_next = in_left_reg | in_right_reg;
                in_left_next  = 1'b0;
            end
            OP_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_left_reg  <= 1'b0;
            in_right_reg <= 1'b0;
        end else begin
            in_left_reg  <= in_left_next;
            in_right_reg <= in_right_next;
        end
    end

    assign state_o = '{word: word_reg, in_left: in_left_reg, in_right: in_right_reg};

endmodule

`default_nettype wire

// ===== hdl/rbd_ctrl.sv =====
// command sequencer, occupancy count and result register of the deque
`default_nettype none

module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    input  wire chain_stat_t stat,
    output chain_ctl_t       ctl
);

    fsm_e             state_reg, state_next;
    in_beat_t         cmd_reg;
    logic [CNT_W-1:0] occ_reg, occ_next;
    out_beat_t        out_reg, res;
    logic             out_valid_reg;

    in_beat_t cur_cmd;
    logic     out_free;
    logic     is_front;
    logic     is_pop;
    logic     is_empty;
    logic     is_full;
    logic     need_mig;
    logic     do_exec;

    assign out_free = !out_valid_reg || m_ready;
    assign cur_cmd  = (state_reg == FSM_IDLE) ? s_data : cmd_reg;
    assign is_front = (cur_cmd.func == FN_PUSH_FRONT) || (cur_cmd.func == FN_POP_FRONT);
    assign is_pop   = (cur_cmd.func == FN_POP_FRONT) || (cur_cmd.func == FN_POP_BACK);
    assign is_empty = (occ_reg == '0);
    assign is_full  = (occ_reg == CNT_W'(DEPTH));
    // a pop whose end segment is empty must first pull the other segment over
    assign need_mig = is_pop && !is_empty &&
                      (is_front ? !stat.front_in_left : !stat.back_in_right);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    if (need_mig) begin
                        state_next = FSM_MIGRATE;
                    end else if (!out_free) begin
                        state_next = FSM_EXEC;
                    end
                end
            end
            FSM_MIGRATE: begin
                if (is_front ? stat.front_in_right : stat.back_in_left) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // outputs and chain command
    always_comb begin
        s_ready  = 1'b0;
        do_exec  = 1'b0;
        ctl.op   = OP_HOLD;
        ctl.word = cur_cmd.value;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                do_exec = s_valid && !need_mig && out_free;
            end
            FSM_MIGRATE: begin
                if (is_front) begin
                    ctl.op = stat.front_in_right ? OP_CONV_L : OP_SHIFT_L;
                end else begin
                    ctl.op = stat.back_in_left ? OP_CONV_R : OP_SHIFT_R;
                end
            end
            FSM_EXEC: begin
                do_exec = out_free;
            end
            default: begin
            end
        endcase

        res.status      = ST_PUSHED;
        res.popped_word = '0;
        res.matches_res = 1'b0;
        occ_next        = occ_reg;
        unique case (cur_cmd.func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (is_full) begin
                    res.status = ST_FULL;
                end else begin
                    occ_next = occ_reg + CNT_W'(1);
                    if (do_exec) begin
                        ctl.op = is_front ? OP_PUSH_F : OP_PUSH_B;
                    end
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (is_empty) begin
                    res.status      = ST_EMPTY;
                    res.popped_word = EMPTY_WORD;
                end else begin
                    res.status      = ST_POPPED;
                    res.popped_word = is_front ? stat.front_word : stat.back_word;
                    occ_next        = occ_reg - CNT_W'(1);
                    if (do_exec) begin
                        ctl.op = is_front ? OP_POP_F : OP_POP_B;
                    end
                end
                res.matches_res = (res.popped_word == cur_cmd.value);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_exec) begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_data;
        end
        if (do_exec) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== hdl/ring_buffer_deque.sv =====
// top level of the ring buffer deque: sequencer and chain of storage cells
//
// usage
//   s_ channel: one command beat {func, value}; push front/back or pop front/back
//   m_ channel: exactly one result beat {status, popped_word, matches_res} per command
//   the deque lives in a row of DEPTH cells; the front segment grows from cell 0,
//   the back segment grows from the last cell, with free cells between them
//   pushes, and pops on an end whose segment holds words, go straight to the
//   chain: the result beat is registered, one command per cycle while the
//   output register is free
//   a pop on an end whose segment is empty while the other end holds words
//   first slides that segment across the row one cell per cycle, then hands it
//   over to the popped end and then pops, so its result comes later than usual
//   while a command is in work s_ready is low; in idle s_ready is high
//   a result beat waits in the output register while m_ready is low; one more
//   command is taken meanwhile and is held until the register frees up
//   reset (aresetn low, synchronous) empties the deque and drops any pending
//   result; stored words are not cleared and are never read before a push
`default_nettype none

module ring_buffer_deque
    import rbd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_beat_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_beat_t     m_data
);

    chain_ctl_t  ctl;
    chain_stat_t stat;
    cell_t       left_edge;
    cell_t       right_edge;
    cell_t       cell_q [DEPTH];

    // command sequencing, counts and the result register
    rbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .stat    (stat),
        .ctl     (ctl)
    );

    // outer neighbors of the two end cells: the pushed word enters here,
    // segment flags only enter on a push at that end
    assign left_edge  = '{word: ctl.word, in_left: (ctl.op == OP_PUSH_F), in_right: 1'b0};
    assign right_edge = '{word: ctl.word, in_left: 1'b0, in_right: (ctl.op == OP_PUSH_B)};

    // the row of cells, each linked to its two neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_t left_nb;
        cell_t right_nb;

        if (i == 0) begin : g_first
            assign left_nb = left_edge;
        end else begin : g_inner_l
            assign left_nb = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_nb = right_edge;
        end else begin : g_inner_r
            assign right_nb = cell_q[i+1];
        end

        rbd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (ctl.op),
            .left_i  (left_nb),
            .right_i (right_nb),
            .state_o (cell_q[i])
        );
    end

    // both ends are read at fixed cells
    assign stat.front_word     = cell_q[0].word;
    assign stat.front_in_left  = cell_q[0].in_left;
    assign stat.front_in_right = cell_q[0].in_right;
    assign stat.back_word      = cell_q[DEPTH-1].word;
    assign stat.back_in_left   = cell_q[DEPTH-1].in_left;
    assign stat.back_in_right  = cell_q[DEPTH-1].in_right;

endmodule

`default_nettype wire

// ===== tb/sv/rbd_checker.sv =====
// deque result checker: watches both channels, predicts each result and compares
`timescale 1ns / 100ps

module rbd_checker
    import rbd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  in_beat_t  s_data,
    input  wire logic m_valid,
    input  wire logic m_ready,
    input  out_beat_t m_data,
    output int        error_count,
    output int        replies_due
);

    localparam int IDX_W = $clog2(DEPTH);

    // shadow copy of the deque
    logic signed [WORD_W-1:0] shadow_slots [DEPTH];
    logic [IDX_W-1:0]         shadow_head;
    logic [IDX_W-1:0]         shadow_tail;
    int                       shadow_fill;

    out_beat_t awaited_replies [$];
    int        errs = 0;

    task automatic predict_reply(input in_beat_t cmd, output out_beat_t reply);
        logic front;
        front = (cmd.func == FN_PUSH_FRONT) || (cmd.func == FN_POP_FRONT);
        reply.status      = ST_PUSHED;
        reply.popped_word = '0;
        reply.matches_res = 1'b0;
        if (cmd.func == FN_PUSH_FRONT || cmd.func == FN_PUSH_BACK) begin
            if (shadow_fill >= DEPTH) begin
                reply.status = ST_FULL;
            end else begin
                if (shadow_fill == 0) begin
                    // lone word: both ends meet on the slot of the pushed end
                    if (front) shadow_tail = shadow_head;
                    else       shadow_head = shadow_tail;
                end else if (front) begin
                    shadow_head = shadow_head - 1'b1;
                end else begin
                    shadow_tail = shadow_tail + 1'b1;
                end
                shadow_slots[front ? shadow_head : shadow_tail] = cmd.value;
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                reply.status      = ST_EMPTY;
                reply.popped_word = EMPTY_WORD;
            end else if (front) begin
                reply.status      = ST_POPPED;
                reply.popped_word = shadow_slots[shadow_head];
                shadow_head       = shadow_head + 1'b1;
                shadow_fill--;
            end else begin
                reply.status      = ST_POPPED;
                reply.popped_word = shadow_slots[shadow_tail];
                shadow_tail       = shadow_tail - 1'b1;
                shadow_fill--;
            end
            reply.matches_res = (reply.popped_word == cmd.value);
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t reply;
        out_beat_t want;
        if (!aresetn) begin
            awaited_replies.delete();
            shadow_head = '0;
            shadow_tail = '0;
            shadow_fill = 0;
            replies_due <= 0;
            error_count <= errs;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: stray result: status %0d word %0d match %0b",
                                 $realtime, m_data.status, m_data.popped_word,
                                 m_data.matches_res);
                end else begin
                    want = awaited_replies[0];
                    awaited_replies.delete(0);
                    if (m_data.status !== want.status ||
                        m_data.popped_word !== want.popped_word ||
                        m_data.matches_res !== want.matches_res) begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                     $realtime, want.status, want.popped_word,
                                     want.matches_res, m_data.status,
                                     m_data.popped_word, m_data.matches_res);
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_reply(s_data, reply);
                awaited_replies.insert(awaited_replies.size(), reply);
            end
            replies_due <= awaited_replies.size();
            error_count <= errs;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the deque testbench: clock, reset, command stimulus, result stalls, verdict
`timescale 1ns / 100ps

module tb_top
    import rbd_pkg::*;
();

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    int error_count;
    int replies_due;

    // words held as seen from the command side, used only to steer stimulus
    int deque_level;
    // beats left in the current sender burst
    int burst_left;
    // long receiver hold-off asked for by the stimulus, in cycles
    int stall_order;

    typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

    ring_buffer_deque dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rbd_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (error_count),
        .replies_due (replies_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // drive one command beat at the falling edge and hold it until taken
    task automatic send_cmd(input func_e fn, input logic signed [WORD_W-1:0] word);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= '{func: fn, value: word};
        do @(posedge aclk); while (!s_ready);
        if (fn == FN_PUSH_FRONT || fn == FN_PUSH_BACK) begin
            if (deque_level < DEPTH) deque_level++;
        end else if (deque_level > 0) begin
            deque_level--;
        end
    endtask

    // drop valid for a number of cycles
    task automatic pause_sender(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // bursts of random length, often split by short gaps, sometimes back to back
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
        end
        burst_left--;
    endtask

    // hold off until every command has its result
    task automatic wait_drained();
        pause_sender(1);
        while (replies_due != 0) @(posedge aclk);
    endtask

    // small words make pops match often; -1 and the extremes come up too
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom_range(0, 3);
            3:       return EMPTY_WORD;
            4:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic func_e pick_push();
        return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    endfunction

    function automatic func_e pick_pop();
        return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
    endfunction

    // receiver: stalls on its own pattern, or holds off for a long stretch on request
    initial begin
        rx_mode_e mode;
        int       span;
        int       hold;
        m_ready = 1'b0;
        mode    = RX_OPEN;
        span    = 0;
        forever begin
            @(negedge aclk);
            if (stall_order > 0) begin
                hold        = stall_order;
                stall_order = 0;
                m_ready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end else begin
                if (span == 0) begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                    default:   m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int roll;
        int push_bias;
        s_valid     = 1'b0;
        s_data      = '0;
        aresetn     = 1'b0;
        deque_level = 0;
        burst_left  = 0;
        stall_order = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // pops on an empty deque, with and without -1 as the expected word
        send_cmd(FN_POP_FRONT, EMPTY_WORD);
        send_cmd(FN_POP_BACK, 32'sd0);
        // extremes at both ends, popped back with a match and a miss
        send_cmd(FN_PUSH_BACK, 32'sh7fff_ffff);
        send_cmd(FN_PUSH_FRONT, 32'sh8000_0000);
        send_cmd(FN_POP_BACK, 32'sh7fff_ffff);
        // back side now empty: the pop takes the word from the far end
        send_cmd(FN_POP_BACK, 32'sd0);
        send_cmd(FN_POP_FRONT, 32'sd5);
        // push into an empty deque after pops moved the ends
        send_cmd(FN_PUSH_FRONT, EMPTY_WORD);
        send_cmd(FN_POP_BACK, EMPTY_WORD);
        send_cmd(FN_PUSH_BACK, 32'sd0);
        send_cmd(FN_PUSH_BACK, 32'sd1);
        send_cmd(FN_PUSH_FRONT, 32'sha5a5_a5a5);
        send_cmd(FN_POP_FRONT, 32'sha5a5_a5a5);
        send_cmd(FN_POP_FRONT, 32'sd0);
        send_cmd(FN_POP_FRONT, 32'sd0);
        send_cmd(FN_POP_BACK, EMPTY_WORD);
        send_cmd(FN_PUSH_FRONT, 32'sh5a5a_5a5a);
        send_cmd(FN_PUSH_FRONT, 32'sh1234_5678);
        send_cmd(FN_POP_BACK, 32'sh5a5a_5a5a);
        send_cmd(FN_POP_FRONT, 32'sh1234_5678);
        send_cmd(FN_POP_BACK, 32'sd3);
        wait_drained();

        // random mix, leaning toward pushes when low and pops when higher
        repeat (540) begin
            pace_sender();
            roll      = $urandom_range(0, 99);
            push_bias = (deque_level < 8) ? 65 : (deque_level > 40) ? 35 : 50;
            send_cmd(roll < push_bias ? pick_push() : pick_pop(), pick_word());
        end
        wait_drained();

        // long receiver hold-off while commands keep coming, so the input stalls
        stall_order = 300;
        repeat (40) begin
            send_cmd($urandom_range(0, 2) != 0 ? pick_push() : pick_pop(), pick_word());
        end
        wait_drained();

        // quiet tail long enough for a stray beat to show up
        repeat (DEPTH + 16) @(posedge aclk);
        if (error_count == 0 && replies_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #120ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
